// File: src/paem_pkg.sv
// Shared constants and types for the power attention event monitor.
`default_nettype none

package paem_pkg;

	// Set-1 scancodes watched by the monitor.
	localparam logic [7:0] SC_PREFIX  = 8'he0;
	localparam logic [7:0] SC_BREAK   = 8'h80;
	localparam logic [7:0] SC_CTRL_MK = 8'h1d;
	localparam logic [7:0] SC_CTRL_BK = SC_CTRL_MK | SC_BREAK;
	localparam logic [7:0] SC_ALT_MK  = 8'h38;
	localparam logic [7:0] SC_ALT_BK  = SC_ALT_MK | SC_BREAK;
	localparam logic [7:0] SC_DEL_MK  = 8'h53;
	localparam logic [7:0] SC_DEL_BK  = 8'hd3;

	// Power button status bit position in the PM1 status words.
	localparam int PWR_BIT = 8;

	localparam int STATUS_W = 16;
	localparam int COUNT_W  = 32;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		ACT_NONE     = 2'd0,
		ACT_REBOOT   = 2'd1,
		ACT_SHUTDOWN = 2'd2
	} action_t;

	typedef enum logic {
		OP_SCANCODE = 1'b0,
		OP_STATUS   = 1'b1
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_ENABLE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER_BUTTON_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PM1B_PRESENT        = 2'd2;

endpackage

`default_nettype wire

// File: src/power_attention_event_monitor.sv
// Power attention event monitor: Ctrl+Alt+Delete and power button detection.
//
// Usage: input beats carry either a set-1 scancode byte (op 0) or a pair of
// PM1a/PM1b status samples (op 1). Each accepted beat yields exactly one
// result beat: an action (none, reboot, shutdown), the W1C clear requests for
// the power button bits, and both wrapping hit counters after that beat.
// A beat is taken on an edge with in_valid high and in_stall low; a result
// is taken on an edge with out_valid high and out_stall low.
// Path: a beat accepted at an edge lands in the input register, and its result
// is loaded into the output register once that register is empty or being
// taken, and out_valid rises with that load. Throughput is one beat per cycle
// while the receiver does not stall, set by the single flag/counter update
// between the input and output registers.
// When the receiver stalls, the output register holds its result and the
// input register holds one more beat; in_stall then rises until the output
// drains. Reset clears the enables, the key flags and both counters and
// empties both registers. Configuration writes (cfg_valid/cfg_ready) are
// always ready and must be made only while the block is idle.
`default_nettype none

module power_attention_event_monitor (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration
	input  wire logic                               cfg_valid,
	output      logic                               cfg_ready,
	input  wire logic [paem_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic                               cfg_data,
	// input items
	input  wire logic                               in_valid,
	output      logic                               in_stall,
	input  wire logic                               op,
	input  wire logic [7:0]                         scan_code,
	input  wire logic [paem_pkg::STATUS_W-1:0]      pm1a_status,
	input  wire logic [paem_pkg::STATUS_W-1:0]      pm1b_status,
	// results
	output      logic                               out_valid,
	input  wire logic                               out_stall,
	output      logic [1:0]                         action,
	output      logic                               clear_pm1a,
	output      logic                               clear_pm1b,
	output      logic [paem_pkg::COUNT_W-1:0]       combo_hits,
	output      logic [paem_pkg::COUNT_W-1:0]       button_hits
);

	logic monitor_enable_q;
	logic power_button_enable_q;
	logic pm1b_present_q;

	logic extended_prefix_q;
	logic ctrl_held_q;
	logic alt_held_q;
	logic delete_held_q;
	logic [paem_pkg::COUNT_W-1:0] combo_count_q;
	logic [paem_pkg::COUNT_W-1:0] button_count_q;

	// input register
	logic                          valid_s1;
	logic                          op_s1;
	logic [7:0]                    scan_s1;
	logic                          pwr_a_s1;
	logic                          pwr_b_s1;

	logic adv_s1;
	logic in_accept;

	assign cfg_ready = 1'b1;
	assign adv_s1    = ~out_valid | ~out_stall;
	assign in_stall  = valid_s1 & ~adv_s1;
	assign in_accept = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			monitor_enable_q      <= 1'b0;
			power_button_enable_q <= 1'b0;
			pm1b_present_q        <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				paem_pkg::CFG_MONITOR_ENABLE:      monitor_enable_q <= cfg_data;
				paem_pkg::CFG_POWER_BUTTON_ENABLE: power_button_enable_q <= cfg_data;
				paem_pkg::CFG_PM1B_PRESENT:        pm1b_present_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// only the power button bits of the status words matter
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1    <= op;
			scan_s1  <= scan_code;
			pwr_a_s1 <= pm1a_status[paem_pkg::PWR_BIT];
			pwr_b_s1 <= pm1b_status[paem_pkg::PWR_BIT];
		end
	end

	// next state and result for the beat in the input register
	logic                          prefix_d;
	logic                          ctrl_d;
	logic                          alt_d;
	logic                          del_d;
	logic                          combo_hit;
	logic                          button_hit;
	logic                          clr_a_d;
	logic                          clr_b_d;
	paem_pkg::action_t             action_d;
	logic [paem_pkg::COUNT_W-1:0]  combo_d;
	logic [paem_pkg::COUNT_W-1:0]  button_d;

	always_comb begin
		prefix_d   = extended_prefix_q;
		ctrl_d     = ctrl_held_q;
		alt_d      = alt_held_q;
		del_d      = delete_held_q;
		combo_hit  = 1'b0;
		button_hit = 1'b0;
		clr_a_d    = 1'b0;
		clr_b_d    = 1'b0;
		action_d   = paem_pkg::ACT_NONE;
		if (monitor_enable_q) begin
			if (op_s1 == paem_pkg::OP_SCANCODE) begin
				if (scan_s1 == paem_pkg::SC_PREFIX) begin
					prefix_d = 1'b1;
				end else begin
					// left and right codes match; the prefix is only dropped
					prefix_d = 1'b0;
					unique case (scan_s1)
						paem_pkg::SC_CTRL_MK: ctrl_d = 1'b1;
						paem_pkg::SC_CTRL_BK: ctrl_d = 1'b0;
						paem_pkg::SC_ALT_MK:  alt_d  = 1'b1;
						paem_pkg::SC_ALT_BK:  alt_d  = 1'b0;
						paem_pkg::SC_DEL_MK:  del_d  = 1'b1;
						paem_pkg::SC_DEL_BK:  del_d  = 1'b0;
						default: ;
					endcase
					combo_hit = ctrl_d & alt_d & del_d;
				end
				if (combo_hit) begin
					action_d = paem_pkg::ACT_REBOOT;
				end
			end else if (power_button_enable_q) begin
				if (pwr_a_s1) begin
					clr_a_d    = 1'b1;
					clr_b_d    = pm1b_present_q;
					button_hit = 1'b1;
				end else if (pm1b_present_q && pwr_b_s1) begin
					clr_b_d    = 1'b1;
					button_hit = 1'b1;
				end
				if (button_hit) begin
					action_d = paem_pkg::ACT_SHUTDOWN;
				end
			end
		end
		combo_d  = combo_count_q + paem_pkg::COUNT_W'(combo_hit);
		button_d = button_count_q + paem_pkg::COUNT_W'(button_hit);
	end

	logic fire_s1;
	assign fire_s1 = valid_s1 & adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extended_prefix_q <= 1'b0;
			ctrl_held_q       <= 1'b0;
			alt_held_q        <= 1'b0;
			delete_held_q     <= 1'b0;
			combo_count_q     <= '0;
			button_count_q    <= '0;
			out_valid         <= 1'b0;
		end else begin
			if (fire_s1) begin
				extended_prefix_q <= prefix_d;
				ctrl_held_q       <= ctrl_d;
				alt_held_q        <= alt_d;
				delete_held_q     <= del_d;
				combo_count_q     <= combo_d;
				button_count_q    <= button_d;
				out_valid         <= 1'b1;
			end else if (adv_s1) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			action      <= action_d;
			clear_pm1a  <= clr_a_d;
			clear_pm1b  <= clr_b_d;
			combo_hits  <= combo_d;
			button_hits <= button_d;
		end
	end

	// clears go out only with a shutdown request
	a_clear_with_shutdown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (clear_pm1a || clear_pm1b) |-> action == paem_pkg::ACT_SHUTDOWN)
		else $error("PM1 clear requested without shutdown");

	// a beat leaving the input register always lands in the output register
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> out_valid)
		else $error("result lost between input and output register");

	// a stalled output holds its result and the counters
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(combo_hits)
			&& $stable(button_hits) && $stable(combo_count_q) && $stable(button_count_q))
		else $error("stalled result or counters changed");

	// the input side stalls only when a beat is already waiting
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid)
		else $error("input stalled with room available");

endmodule

`default_nettype wire

// File: sim/tb_power_attention_event_monitor.sv
// Self-checking testbench for the power attention event monitor.
module tb_power_attention_event_monitor;
	timeunit 1ns;
	timeprecision 1ps;

	import paem_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 4;
	localparam int RAND_PHASES  = 10;
	localparam int BEATS_ACTIVE = 195;
	localparam int BEATS_QUIET  = 40;

	// No register sits at this index; a write must leave every setting alone.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam logic [7:0] MAKE_CODES [3]  = '{SC_CTRL_MK, SC_ALT_MK, SC_DEL_MK};
	localparam logic [7:0] BREAK_CODES [3] = '{SC_CTRL_BK, SC_ALT_BK, SC_DEL_BK};
	localparam logic [7:0] WATCHED_CODES [7] = '{SC_PREFIX, SC_CTRL_MK, SC_CTRL_BK,
		SC_ALT_MK, SC_ALT_BK, SC_DEL_MK, SC_DEL_BK};

	// Settings per random phase: bit 0 monitor, bit 1 button, bit 2 pm1b.
	localparam logic [2:0] PHASE_SETTINGS [RAND_PHASES] = '{3'b111, 3'b011, 3'b101,
		3'b001, 3'b111, 3'b000, 3'b110, 3'b011, 3'b111, 3'b101};

	typedef struct packed {
		op_t               op;
		logic [7:0]        scan_code;
		logic [STATUS_W-1:0] pm1a;
		logic [STATUS_W-1:0] pm1b;
	} event_t;

	typedef struct packed {
		action_t            action;
		logic               clr_a;
		logic               clr_b;
		logic [COUNT_W-1:0] combo;
		logic [COUNT_W-1:0] button;
	} verdict_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_MONITOR_ENABLE;
	logic                 cfg_data = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	event_t               on_bus = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           action;
	logic                 clear_pm1a;
	logic                 clear_pm1b;
	logic [COUNT_W-1:0]   combo_hits;
	logic [COUNT_W-1:0]   button_hits;

	// predictor copy of settings and state
	logic               mon_en = 1'b0;
	logic               btn_en = 1'b0;
	logic               pm1b_on = 1'b0;
	logic               e0_pending = 1'b0;
	logic               ctrl_dn = 1'b0;
	logic               alt_dn = 1'b0;
	logic               del_dn = 1'b0;
	logic [COUNT_W-1:0] combo_cnt = '0;
	logic [COUNT_W-1:0] button_cnt = '0;

	event_t   pending_q [$];
	verdict_t verdict_q [$];
	int       err_cnt = 0;
	int       idle_cycles = 0;
	int       stall_clk = 0;
	int       burst_left = 1;
	int       gap_left = 0;

	power_attention_event_monitor dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (on_bus.op),
		.scan_code  (on_bus.scan_code),
		.pm1a_status(on_bus.pm1a),
		.pm1b_status(on_bus.pm1b),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.action     (action),
		.clear_pm1a (clear_pm1a),
		.clear_pm1b (clear_pm1b),
		.combo_hits (combo_hits),
		.button_hits(button_hits)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Advance the key and button state by one beat and return its result.
	function automatic verdict_t track_event(event_t ev);
		verdict_t v;
		v = '0;
		v.action = ACT_NONE;
		if (mon_en) begin
			if (ev.op == OP_SCANCODE) begin
				if (ev.scan_code == SC_PREFIX) begin
					e0_pending = 1'b1;
				end else begin
					// right-hand keys share the left-hand codes, only the prefix differs
					e0_pending = 1'b0;
					case (ev.scan_code)
						SC_CTRL_MK: ctrl_dn = 1'b1;
						SC_CTRL_BK: ctrl_dn = 1'b0;
						SC_ALT_MK:  alt_dn = 1'b1;
						SC_ALT_BK:  alt_dn = 1'b0;
						SC_DEL_MK:  del_dn = 1'b1;
						SC_DEL_BK:  del_dn = 1'b0;
						default: ;
					endcase
					if (ctrl_dn && alt_dn && del_dn) begin
						combo_cnt = combo_cnt + COUNT_W'(1);
						v.action = ACT_REBOOT;
					end
				end
			end else if (btn_en) begin
				if (ev.pm1a[PWR_BIT]) begin
					v.clr_a = 1'b1;
					v.clr_b = pm1b_on;
					v.action = ACT_SHUTDOWN;
				end else if (pm1b_on && ev.pm1b[PWR_BIT]) begin
					v.clr_b = 1'b1;
					v.action = ACT_SHUTDOWN;
				end
				if (v.action == ACT_SHUTDOWN) begin
					button_cnt = button_cnt + COUNT_W'(1);
				end
			end
		end
		v.combo = combo_cnt;
		v.button = button_cnt;
		return v;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			err_cnt++;
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
		end
	endtask

	// Sender: bursts of beats separated by random gaps; hold a stalled beat.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				verdict_q.push_back(track_event(on_bus));
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					on_bus <= pending_q.pop_front();
					in_valid <= 1'b1;
					burst_left = burst_left - 1;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						case ($urandom_range(0, 9))
							0, 1, 2: gap_left = 0;
							3, 4, 5, 6, 7: gap_left = $urandom_range(1, 4);
							default: gap_left = $urandom_range(5, 20);
						endcase
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result beat, stall on a rotating pattern, watch for hangs.
	always @(posedge clk) begin
		verdict_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					err_cnt++;
					$error("result beat with no prediction pending");
				end else begin
					want = verdict_q.pop_front();
					compare_field("action", 32'(want.action), 32'(action));
					compare_field("clear_pm1a", 32'(want.clr_a), 32'(clear_pm1a));
					compare_field("clear_pm1b", 32'(want.clr_b), 32'(clear_pm1b));
					compare_field("combo_hits", want.combo, combo_hits);
					compare_field("button_hits", want.button, button_hits);
				end
			end

			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end

			stall_clk++;
			case ((stall_clk >> 8) % 4)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 9) < 7);
				default: out_stall <= ((stall_clk % 7) < 3);
			endcase
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MONITOR_ENABLE:      mon_en = val;
			CFG_POWER_BUTTON_ENABLE: btn_en = val;
			CFG_PM1B_PRESENT:        pm1b_on = val;
			default: ;
		endcase
	endtask

	// Wait until every queued beat has gone in and every result has come out.
	task automatic drain();
		@(negedge clk);
		while (pending_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_scan(input logic [7:0] code);
		event_t ev;
		ev.op = OP_SCANCODE;
		ev.scan_code = code;
		ev.pm1a = 16'($urandom());
		ev.pm1b = 16'($urandom());
		pending_q.push_back(ev);
	endtask

	task automatic queue_status(input logic [STATUS_W-1:0] a, input logic [STATUS_W-1:0] b);
		event_t ev;
		ev.op = OP_STATUS;
		ev.scan_code = 8'($urandom());
		ev.pm1a = a;
		ev.pm1b = b;
		pending_q.push_back(ev);
	endtask

	// Mostly three-finger salutes with random prefixes, repeats and stray bytes,
	// the rest status samples and noise.
	task automatic queue_traffic(input int beats);
		int start;
		int k0;
		int k1;
		int order [3];
		logic [STATUS_W-1:0] a;
		logic [STATUS_W-1:0] b;
		start = pending_q.size();
		while (pending_q.size() - start < beats) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8: begin
					k0 = $urandom_range(0, 2);
					k1 = (k0 + $urandom_range(1, 2)) % 3;
					order = '{k0, k1, 3 - k0 - k1};
					foreach (order[j]) begin
						if ($urandom_range(0, 1)) queue_scan(SC_PREFIX);
						queue_scan(MAKE_CODES[order[j]]);
						if ($urandom_range(0, 9) < 3) queue_scan(MAKE_CODES[order[j]]);
						if ($urandom_range(0, 9) < 2) queue_scan(8'($urandom()));
					end
					repeat ($urandom_range(0, 2)) queue_scan(8'($urandom()));
					k0 = $urandom_range(0, 2);
					k1 = (k0 + $urandom_range(1, 2)) % 3;
					order = '{k0, k1, 3 - k0 - k1};
					foreach (order[j]) begin
						if ($urandom_range(0, 9) < 8) begin
							if ($urandom_range(0, 1)) queue_scan(SC_PREFIX);
							queue_scan(BREAK_CODES[order[j]]);
						end
					end
				end
				9, 10, 11, 12: begin
					a = 16'($urandom());
					b = 16'($urandom());
					a[PWR_BIT] = $urandom_range(0, 1);
					b[PWR_BIT] = $urandom_range(0, 1);
					queue_status(a, b);
				end
				13, 14, 15, 16: queue_scan(8'($urandom()));
				default: queue_scan(WATCHED_CODES[$urandom_range(0, 6)]);
			endcase
		end
	endtask

	initial begin
		logic [2:0] setting;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// monitor still off after reset: nothing may move
		queue_scan(SC_CTRL_MK);
		queue_scan(SC_ALT_MK);
		queue_scan(SC_DEL_MK);
		queue_status(16'h0100, 16'h0100);
		drain();

		write_reg(CFG_MONITOR_ENABLE, 1'b1);
		write_reg(CFG_POWER_BUTTON_ENABLE, 1'b1);
		write_reg(CFG_PM1B_PRESENT, 1'b1);
		// right ctrl, left alt, right delete; then the held combo fires again
		queue_scan(SC_PREFIX);
		queue_scan(SC_CTRL_MK);
		queue_scan(SC_ALT_MK);
		queue_scan(SC_PREFIX);
		queue_scan(SC_DEL_MK);
		queue_scan(8'h00);
		queue_scan(SC_PREFIX);
		queue_scan(8'hff);
		queue_scan(SC_DEL_BK);
		queue_scan(SC_CTRL_BK);
		queue_scan(SC_ALT_BK);
		queue_status(16'h0100, 16'h0000);
		queue_status(16'h0000, 16'h0100);
		queue_status(16'hffff, 16'hffff);
		queue_status(16'h0000, 16'h0000);
		queue_status(16'hfeff, 16'hfeff);
		drain();
		write_reg(CFG_PM1B_PRESENT, 1'b0);
		queue_status(16'h0000, 16'h0100);
		queue_status(16'h0100, 16'h0100);
		drain();
		write_reg(CFG_POWER_BUTTON_ENABLE, 1'b0);
		queue_status(16'h0100, 16'h0100);
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			setting = PHASE_SETTINGS[p];
			write_reg(CFG_PM1B_PRESENT, setting[2]);
			write_reg(CFG_MONITOR_ENABLE, setting[0]);
			write_reg(CFG_POWER_BUTTON_ENABLE, setting[1]);
			if (p == RAND_PHASES / 2) write_reg(CFG_UNUSED, 1'b1);
			queue_traffic(setting[0] ? BEATS_ACTIVE : BEATS_QUIET);
			drain();
		end

		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: power_attention_event_monitor.f
src/paem_pkg.sv
src/power_attention_event_monitor.sv
sim/tb_power_attention_event_monitor.sv
